FILE: design/atas_pkg.sv
// Shared types, fixed-point constants and tables of the additive tone synthesiser.
package atas_pkg;

    // shared multiplier operand and product
    localparam int MW = 35;
    typedef logic signed [MW-1:0]   mop_t;
    typedef logic signed [2*MW-1:0] mprod_t;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    typedef enum logic [CFG_AW-1:0] {
        REG_VOICE_COUNT,
        REG_STEP_A,
        REG_STEP_B,
        REG_STEP_C,
        REG_STEP_D,
        REG_NOTE_LENGTH,
        REG_SAMPLE_RATE
    } cfg_reg_t;

    // sine polynomial, Q28
    localparam mop_t Q28_ONE     = mop_t'(268435456);
    localparam mop_t Q28_PI      = mop_t'(843314857);
    localparam mop_t Q28_SIXTH   = mop_t'(44739243);
    localparam mop_t Q28_120TH   = mop_t'(2236962);
    localparam int   SINE_SHIFT  = 41;

    // x2 / 5040 by reciprocal, one correction step
    localparam mop_t DIV_5040          = mop_t'(5040);
    localparam mop_t RECIP_5040        = mop_t'(852176);
    localparam int   RECIP_5040_SHIFT  = 32;

    // v / 5 by reciprocal, exact below 2^18
    localparam mop_t RECIP_5       = mop_t'(52429);
    localparam int   RECIP_5_SHIFT = 18;

    // envelope, clip and output gain, Q15
    localparam logic [16:0] UNITY_Q15   = 17'd32768;
    localparam logic [16:0] SUSTAIN_ENV = 17'd27853;
    localparam mop_t SUSTAIN_Q15    = mop_t'(27853);
    localparam mop_t DECAY_GAIN     = mop_t'(98304);
    localparam mop_t CLIP_Q30       = mop_t'(858993459);
    localparam mop_t CLIP_SLOPE_Q15 = mop_t'(9830);
    localparam mop_t OUT_GAIN_Q15   = mop_t'(29491);
    localparam mop_t FULL_SCALE     = mop_t'(32767);

    localparam logic [15:0] HARM_WEIGHT [8] = '{
        16'd19661, 16'd6554, 16'd3932, 16'd1966, 16'd983, 16'd0, 16'd0, 16'd0
    };

    localparam logic [15:0] INV_SQRT_Q15 [8] = '{
        16'd32768, 16'd23170, 16'd18919, 16'd16384,
        16'd14654, 16'd13377, 16'd12385, 16'd11585
    };

endpackage

FILE: design/additive_tone_adsr_synth_core.sv
// Additive tone synthesiser core: sequencer around one shared multiplier and a divider.
// Each request runs the envelope (divider in attack, decay and release, none in sustain), then
//   the sine loop over every harmonic of every voice, then mix, clip and gain; a note-over
//   request goes straight to its silent result.
// One request at a time: the next is taken once the result has moved to the output register
//   and the sequencer is back in idle; each harmonic takes eight multiplier passes.
// Reset (rst_n low, asynchronous): registers to defaults, index and phases zero, idle.
module additive_tone_adsr_synth_core #(
    parameter int MAX_VOICES = 4,
    parameter int HARMONICS  = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        restart,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [15:0]          sample_value,
    output logic                        last_sample,
    output logic                        ended,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [atas_pkg::CFG_AW-1:0] cfg_index,
    input  logic [atas_pkg::CFG_DW-1:0] cfg_data
);
    import atas_pkg::*;

    localparam int VW   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int HW   = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
    localparam int D_NW = 39;
    localparam int D_DW = 27;

    typedef enum logic [4:0] {
        S_IDLE, S_ENV0, S_ENV1, S_ENV_NUM, S_ENV_DIV, S_ENV_BOOST, S_ENV_FIN,
        S_SIN_T, S_SIN_X, S_SIN_X2, S_SIN_Q0, S_SIN_A, S_SIN_B, S_SIN_C, S_SIN_S,
        S_SIN_ACC, S_MIX, S_M1, S_M2, S_CLIP, S_GAIN, S_MAG, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ENV_ATTACK, ENV_DECAY, ENV_SUSTAIN, ENV_RELEASE
    } env_seg_t;

    state_t state_reg;

    // configuration registers
    logic [2:0]  voice_count_reg;
    logic [31:0] step_reg [4];
    logic [23:0] note_length_reg;
    logic [17:0] sample_rate_reg;

    // note state
    logic [23:0] sample_index_reg;
    logic [31:0] phase_reg [MAX_VOICES];

    // envelope working set
    logic [19:0] at_reg;
    logic [21:0] dc_reg;
    logic [22:0] rl_reg;
    logic [30:0] t_reg;
    logic [30:0] hl_reg;
    logic        boost_reg;
    env_seg_t    seg_reg;
    logic [16:0] env_raw_reg;
    logic [16:0] env_reg;

    // harmonic loop
    logic [3:0]    n_reg;
    logic [VW-1:0] v_reg;
    logic [HW-1:0] h_reg;
    logic [31:0]   hp_reg;
    mop_t          x_reg, x2_reg, q0_reg, mix_reg, m2_reg;
    logic          clip_hi_reg, clip_lo_reg, neg_reg;

    // result and output registers
    logic signed [15:0] res_value_reg;
    logic               res_last_reg, res_ended_reg;
    logic               out_valid_reg;
    logic signed [15:0] sample_value_reg;
    logic               last_sample_reg, ended_reg;

    // shared units
    mop_t             mul_a, mul_b;
    mprod_t           mul_prod;
    logic             div_start, div_busy;
    logic [D_NW-1:0]  div_num, div_quot;
    logic [D_DW-1:0]  div_den;

    atas_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    atas_div #(.NW(D_NW), .DW(D_DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // ---------------------------------------------------------------
    // Envelope times, hundredths of a sample
    // ---------------------------------------------------------------
    logic [19:0] r3;
    logic [24:0] l2;
    logic [21:0] r10;
    logic [26:0] l6;
    logic [22:0] r30;
    logic [27:0] l15;
    logic [19:0] at_next;
    logic [21:0] dc_next;
    logic [22:0] rl_next;
    logic [30:0] t_next, hl_next;

    assign r3  = 20'({sample_rate_reg, 1'b0}) + 20'(sample_rate_reg);
    assign l2  = {note_length_reg, 1'b0};
    assign r10 = 22'({sample_rate_reg, 3'b0}) + 22'({sample_rate_reg, 1'b0});
    assign l6  = 27'({note_length_reg, 2'b0}) + 27'({note_length_reg, 1'b0});
    assign r30 = 23'({sample_rate_reg, 5'b0}) - 23'({sample_rate_reg, 1'b0});
    assign l15 = 28'({note_length_reg, 4'b0}) - 28'(note_length_reg);

    assign at_next = (25'(r3)  < l2)  ? r3  : l2[19:0];
    assign dc_next = (27'(r10) < l6)  ? r10 : l6[21:0];
    assign rl_next = (28'(r30) < l15) ? r30 : l15[22:0];

    // 100 * x as 64x + 32x + 4x
    assign t_next  = 31'({sample_index_reg, 6'b0}) + 31'({sample_index_reg, 5'b0})
                   + 31'({sample_index_reg, 2'b0});
    assign hl_next = 31'({note_length_reg, 6'b0}) + 31'({note_length_reg, 5'b0})
                   + 31'({note_length_reg, 2'b0});

    logic [22:0] ss;
    logic [30:0] rs;
    env_seg_t    seg_next;

    assign ss = 23'(at_reg) + 23'(dc_reg);
    assign rs = hl_reg - 31'(rl_reg);

    always_comb
    begin
        priority if (t_reg < 31'(at_reg))
            seg_next = ENV_ATTACK;
        else if (t_reg < 31'(ss))
            seg_next = ENV_DECAY;
        else if (t_reg < rs || rl_reg == '0)
            seg_next = ENV_SUSTAIN;
        else
            seg_next = ENV_RELEASE;
    end

    logic [18:0] env6;
    assign env6 = 19'({env_raw_reg, 2'b0}) + 19'({env_raw_reg, 1'b0});

    // ---------------------------------------------------------------
    // Values taken from the product register
    // ---------------------------------------------------------------
    mop_t   x_next, x2_next, q0_next, rem5040, q_next, a_next, b_next, c_next;
    mop_t   m_shift, s_next, m3_next, mag_in;
    mprod_t s_wide, mag_full;
    logic [15:0] mag16;

    assign x_next  = mop_t'(mul_prod >>> 31);
    assign x2_next = mop_t'(mul_prod >>> 28);
    assign q0_next = mop_t'(mul_prod >>> RECIP_5040_SHIFT);
    assign rem5040 = x2_reg - mop_t'(mul_prod);
    assign q_next  = q0_reg + ((rem5040 >= DIV_5040) ? mop_t'(1) : mop_t'(0));
    assign a_next  = Q28_120TH - q_next;
    assign b_next  = Q28_SIXTH - mop_t'(mul_prod >>> 28);
    assign c_next  = Q28_ONE - mop_t'(mul_prod >>> 28);
    assign s_wide  = mul_prod >>> SINE_SHIFT;
    assign m_shift = mop_t'(mul_prod >>> 15);
    assign mag_in  = (m_shift < 0) ? -m_shift : m_shift;
    assign mag_full = mul_prod >>> 30;
    assign mag16   = (mag_full > mprod_t'(FULL_SCALE)) ? 16'd32767 : 16'(mag_full);

    // sine saturates to the Q1.15 range
    always_comb
    begin
        priority if (s_wide > mprod_t'(32767))
            s_next = mop_t'(32767);
        else if (s_wide < -mprod_t'(32768))
            s_next = -mop_t'(32768);
        else
            s_next = mop_t'(s_wide);
    end

    always_comb
    begin
        priority if (clip_hi_reg)
            m3_next = CLIP_Q30 + m_shift;
        else if (clip_lo_reg)
            m3_next = m_shift - CLIP_Q30;
        else
            m3_next = m2_reg;
    end

    logic [VW-1:0] v_inc;
    logic          last_harm, last_voice;

    assign v_inc      = v_reg + 1'b1;
    assign last_harm  = (4'(h_reg) + 4'd1) == 4'(HARMONICS);
    assign last_voice = (4'(v_reg) + 4'd1) == n_reg;

    // ---------------------------------------------------------------
    // Operand select for the shared multiplier and divider
    // ---------------------------------------------------------------
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_ENV1:
            begin
                if (seg_next == ENV_DECAY)
                begin
                    mul_a = mop_t'(t_reg - 31'(at_reg));
                    mul_b = DECAY_GAIN;
                end
                else if (seg_next == ENV_RELEASE)
                begin
                    mul_a = mop_t'(hl_reg - t_reg);
                    mul_b = SUSTAIN_Q15;
                end
                else if (seg_next == ENV_ATTACK)
                begin
                    div_start = 1'b1;
                    div_num   = D_NW'({t_reg[19:0], 15'b0});
                    div_den   = D_DW'(at_reg);
                end
            end
            S_ENV_NUM:
            begin
                div_start = 1'b1;
                div_num   = mul_prod[D_NW-1:0];
                // decay divides by 20*dc, release by rl
                div_den   = (seg_reg == ENV_DECAY)
                          ? (D_DW'({dc_reg, 4'b0}) + D_DW'({dc_reg, 2'b0}))
                          : D_DW'(rl_reg);
            end
            S_ENV_BOOST:
            begin
                mul_a = mop_t'(env6);
                mul_b = RECIP_5;
            end
            S_SIN_T:
            begin
                mul_a = mop_t'($signed(hp_reg));
                mul_b = Q28_PI;
            end
            S_SIN_X:
            begin
                mul_a = x_next;
                mul_b = x_next;
            end
            S_SIN_X2:
            begin
                mul_a = x2_next;
                mul_b = RECIP_5040;
            end
            S_SIN_Q0:
            begin
                mul_a = q0_next;
                mul_b = DIV_5040;
            end
            S_SIN_A:
            begin
                mul_a = x2_reg;
                mul_b = a_next;
            end
            S_SIN_B:
            begin
                mul_a = x2_reg;
                mul_b = b_next;
            end
            S_SIN_C:
            begin
                mul_a = x_reg;
                mul_b = c_next;
            end
            S_SIN_S:
            begin
                mul_a = s_next;
                mul_b = mop_t'(HARM_WEIGHT[3'(h_reg)]);
            end
            S_MIX:
            begin
                mul_a = mix_reg;
                mul_b = mop_t'(INV_SQRT_Q15[3'(n_reg - 4'd1)]);
            end
            S_M1:
            begin
                mul_a = m_shift;
                mul_b = mop_t'(env_reg);
            end
            S_M2:
            begin
                mul_a = (m_shift > CLIP_Q30) ? (m_shift - CLIP_Q30) : (m_shift + CLIP_Q30);
                mul_b = CLIP_SLOPE_Q15;
            end
            S_CLIP:
            begin
                mul_a = m3_next;
                mul_b = OUT_GAIN_Q15;
            end
            S_GAIN:
            begin
                mul_a = mag_in;
                mul_b = FULL_SCALE;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer, state and registered outputs
    // ---------------------------------------------------------------
    logic        in_accept;
    logic [23:0] idx_use;
    logic [3:0]  n_next;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign idx_use   = restart ? 24'd0 : sample_index_reg;

    always_comb
    begin
        priority if (voice_count_reg == 3'd0)
            n_next = 4'd1;
        else if ({1'b0, voice_count_reg} > 4'(MAX_VOICES))
            n_next = 4'(MAX_VOICES);
        else
            n_next = {1'b0, voice_count_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            voice_count_reg  <= 3'd1;
            for (int k = 0; k < 4; k++)
            begin
                step_reg[k] <= '0;
            end
            note_length_reg  <= 24'd44100;
            sample_rate_reg  <= 18'd44100;
            sample_index_reg <= '0;
            for (int k = 0; k < MAX_VOICES; k++)
            begin
                phase_reg[k] <= '0;
            end
            at_reg           <= '0;
            dc_reg           <= '0;
            rl_reg           <= '0;
            t_reg            <= '0;
            hl_reg           <= '0;
            boost_reg        <= 1'b0;
            seg_reg          <= ENV_ATTACK;
            env_raw_reg      <= '0;
            env_reg          <= '0;
            n_reg            <= 4'd1;
            v_reg            <= '0;
            h_reg            <= '0;
            hp_reg           <= '0;
            x_reg            <= '0;
            x2_reg           <= '0;
            q0_reg           <= '0;
            mix_reg          <= '0;
            m2_reg           <= '0;
            clip_hi_reg      <= 1'b0;
            clip_lo_reg      <= 1'b0;
            neg_reg          <= 1'b0;
            res_value_reg    <= '0;
            res_last_reg     <= 1'b0;
            res_ended_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            sample_value_reg <= '0;
            last_sample_reg  <= 1'b0;
            ended_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_VOICE_COUNT: voice_count_reg <= cfg_data[2:0];
                    REG_STEP_A:      step_reg[0]     <= cfg_data;
                    REG_STEP_B:      step_reg[1]     <= cfg_data;
                    REG_STEP_C:      step_reg[2]     <= cfg_data;
                    REG_STEP_D:      step_reg[3]     <= cfg_data;
                    REG_NOTE_LENGTH: note_length_reg <= cfg_data[23:0];
                    REG_SAMPLE_RATE: sample_rate_reg <= cfg_data[17:0];
                    default:         ;
                endcase
            end

            // S_DONE reloads the output register itself
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (restart)
                        begin
                            sample_index_reg <= '0;
                            for (int k = 0; k < MAX_VOICES; k++)
                            begin
                                phase_reg[k] <= '0;
                            end
                        end
                        n_reg <= n_next;
                        if (idx_use >= note_length_reg)
                        begin
                            // note over: silent result, nothing advances
                            res_value_reg <= '0;
                            res_last_reg  <= 1'b0;
                            res_ended_reg <= 1'b1;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_ENV0;
                        end
                    end
                end
                S_ENV0:
                begin
                    at_reg    <= at_next;
                    dc_reg    <= dc_next;
                    rl_reg    <= rl_next;
                    t_reg     <= t_next;
                    hl_reg    <= hl_next;
                    boost_reg <= {1'b0, note_length_reg} > 25'({sample_rate_reg, 1'b0});
                    state_reg <= S_ENV1;
                end
                S_ENV1:
                begin
                    seg_reg <= seg_next;
                    unique case (seg_next)
                        ENV_ATTACK:
                        begin
                            state_reg <= S_ENV_DIV;
                        end
                        ENV_SUSTAIN:
                        begin
                            env_raw_reg <= SUSTAIN_ENV;
                            state_reg   <= S_ENV_BOOST;
                        end
                        ENV_DECAY, ENV_RELEASE:
                        begin
                            state_reg <= S_ENV_NUM;
                        end
                    endcase
                end
                S_ENV_NUM:
                begin
                    state_reg <= S_ENV_DIV;
                end
                S_ENV_DIV:
                begin
                    if (!div_busy)
                    begin
                        env_raw_reg <= (seg_reg == ENV_DECAY)
                                     ? (UNITY_Q15 - 17'(div_quot))
                                     : 17'(div_quot);
                        state_reg   <= S_ENV_BOOST;
                    end
                end
                S_ENV_BOOST:
                begin
                    state_reg <= S_ENV_FIN;
                end
                S_ENV_FIN:
                begin
                    // long notes get the 6/5 boost
                    env_reg   <= boost_reg ? 17'(mul_prod >>> RECIP_5_SHIFT) : env_raw_reg;
                    mix_reg   <= '0;
                    v_reg     <= '0;
                    h_reg     <= '0;
                    hp_reg    <= phase_reg[0];
                    state_reg <= S_SIN_T;
                end
                S_SIN_T:
                begin
                    state_reg <= S_SIN_X;
                end
                S_SIN_X:
                begin
                    x_reg     <= x_next;
                    state_reg <= S_SIN_X2;
                end
                S_SIN_X2:
                begin
                    x2_reg    <= x2_next;
                    state_reg <= S_SIN_Q0;
                end
                S_SIN_Q0:
                begin
                    q0_reg    <= q0_next;
                    state_reg <= S_SIN_A;
                end
                S_SIN_A:
                begin
                    state_reg <= S_SIN_B;
                end
                S_SIN_B:
                begin
                    state_reg <= S_SIN_C;
                end
                S_SIN_C:
                begin
                    state_reg <= S_SIN_S;
                end
                S_SIN_S:
                begin
                    state_reg <= S_SIN_ACC;
                end
                S_SIN_ACC:
                begin
                    mix_reg <= mix_reg + mop_t'(mul_prod);
                    priority if (!last_harm)
                    begin
                        // next harmonic: phase times (h+1) by repeated addition
                        h_reg     <= h_reg + 1'b1;
                        hp_reg    <= hp_reg + phase_reg[v_reg];
                        state_reg <= S_SIN_T;
                    end
                    else if (!last_voice)
                    begin
                        v_reg     <= v_inc;
                        h_reg     <= '0;
                        hp_reg    <= phase_reg[v_inc];
                        state_reg <= S_SIN_T;
                    end
                    else
                    begin
                        state_reg <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    m2_reg      <= m_shift;
                    clip_hi_reg <= m_shift > CLIP_Q30;
                    clip_lo_reg <= m_shift < -CLIP_Q30;
                    state_reg   <= S_CLIP;
                end
                S_CLIP:
                begin
                    state_reg <= S_GAIN;
                end
                S_GAIN:
                begin
                    neg_reg   <= m_shift < 0;
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    res_value_reg    <= neg_reg ? -$signed(mag16) : $signed(mag16);
                    res_last_reg     <= ({1'b0, sample_index_reg} + 25'd1)
                                        == {1'b0, note_length_reg};
                    res_ended_reg    <= 1'b0;
                    sample_index_reg <= sample_index_reg + 24'd1;
                    for (int k = 0; k < MAX_VOICES; k++)
                    begin
                        if (k < 4)
                        begin
                            phase_reg[k] <= phase_reg[k] + step_reg[2'(k)];
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        sample_value_reg <= res_value_reg;
                        last_sample_reg  <= res_last_reg;
                        ended_reg        <= res_ended_reg;
                        state_reg        <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_stall     = state_reg != S_IDLE;
    assign out_valid    = out_valid_reg;
    assign sample_value = sample_value_reg;
    assign last_sample  = last_sample_reg;
    assign ended        = ended_reg;

endmodule

FILE: design/atas_mul.sv
// Shared signed multiplier with registered product.
module atas_mul (
    input  logic            clk,
    input  atas_pkg::mop_t  op_a,
    input  atas_pkg::mop_t  op_b,
    output atas_pkg::mprod_t prod
);
    import atas_pkg::*;

    mprod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mprod_t'(op_a) * mprod_t'(op_b);
    end

    assign prod = prod_reg;

endmodule

FILE: design/atas_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module atas_div #(
    parameter int NW = 39,
    parameter int DW = 27
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic [DW:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   shifted;
    logic          fits;

    assign shifted = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(NW);
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            rem_reg <= fits ? (shifted - {1'b0, den_reg}) : shifted;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign busy = cnt_reg != '0;
    assign quot = quo_reg;

endmodule

FILE: design/atas_checker.sv
// Port-level checker for the synthesiser core, bound to the top level.
module atas_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [15:0]          sample_value,
    input  logic                        last_sample,
    input  logic                        ended
);

    // a finished note yields silence and never flags its last sample
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ended |-> sample_value == 16'sd0 && !last_sample)
        else $error("ended result not silent");

    // output saturation is symmetric
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_value != 16'sh8000)
        else $error("sample below -32767");

    // a request keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken back to back");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_value)
                                   && $stable(last_sample) && $stable(ended))
        else $error("stalled result changed");

endmodule

bind additive_tone_adsr_synth_core atas_checker u_atas_checker (.*);
